// File: rtl/ucp_pkg.sv
// shared types, codes and character helpers for the framed command parser
// used by ucp_front, ucp_queue, ucp_back and uart_framed_command_parser
// no dependencies
package ucp_pkg;

	// default line buffer size in bytes, one less is usable
	localparam int LINE_BYTES_DEF = 40;

	// reply queue between front and back, depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;

	// crc-8 generator polynomial
	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef enum logic [1:0] {
		ST_QUERY  = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_FORMAT = 2'd2,
		ST_CHECK  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_PREFIX = 3'd0,
		PH_FIRST  = 3'd1,
		PH_SECOND = 3'd2,
		PH_CHECK  = 3'd3,
		PH_REJECT = 3'd4
	} phase_t;

	// one classified line waiting for its reply
	typedef struct packed {
		status_t     status;
		logic [31:0] first;
		logic [31:0] second;
	} reply_t;

	// queue occupancy seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] b);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			h.val = 4'(b - 8'h30);
		end else if (b inside {[8'h61:8'h66]}) begin
			h.val = 4'(b - 8'h57);
		end else if (b inside {[8'h41:8'h46]}) begin
			h.val = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// one byte of crc-8, msb first, eight shift steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	function automatic logic [7:0] frame_head(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0: c = CH_C;
			2'd1: c = CH_X;
			2'd2: c = CH_ONE;
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] query_head(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0: c = CH_C;
			2'd1: c = CH_X;
			2'd2: c = CH_ONE;
			default: c = CH_QUERY;
		endcase
		return c;
	endfunction

	// character at position idx of the reply text for a status
	function automatic logic [7:0] reply_char(input status_t st, input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_C;
			3'd1: c = CH_X;
			3'd2: c = CH_ONE;
			3'd3: c = (st == ST_QUERY) ? CH_BANG : CH_COMMA;
			3'd4: begin
				case (st)
					ST_QUERY:  c = CH_LF;
					ST_ACCEPT: c = CH_O;
					default:   c = CH_E;
				endcase
			end
			3'd5: c = (st == ST_ACCEPT) ? CH_K : CH_R;
			3'd6: c = (st == ST_ACCEPT) ? CH_LF : CH_R;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	function automatic logic reply_last(input status_t st, input logic [2:0] idx);
		logic l;
		case (st)
			ST_QUERY:  l = (idx == 3'd4);
			ST_ACCEPT: l = (idx == 3'd6);
			default:   l = (idx == 3'd7);
		endcase
		return l;
	endfunction

endpackage

// File: rtl/ucp_front.sv
// front end: takes received bytes, tracks the line parse, classifies on newline
// depends on ucp_pkg
module ucp_front #(
	parameter int LINE_BYTES = ucp_pkg::LINE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rx_valid,
	output logic            rx_stall,
	input  logic [7:0]      rx_byte,
	input  ucp_pkg::qstat_t qstat,
	output logic            push,
	output ucp_pkg::reply_t push_entry
);

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

	ucp_pkg::phase_t phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]  crc_q, crc_d;
	logic        qm_q, qm_d;
	logic [31:0] acc1_q, acc1_d;
	logic [31:0] acc2_q, acc2_d;
	logic [7:0]  rc_q, rc_d;
	logic [1:0]  das_q, das_d;
	logic        fe_q, fe_d;
	logic        cde_q, cde_d;
	logic        te_q, te_d;

	logic           accept;
	logic [1:0]     pos;
	ucp_pkg::hex_t  hx;

	assign rx_stall = qstat.full;
	assign accept   = rx_valid && !rx_stall;
	assign pos      = len_q[1:0];
	assign hx       = ucp_pkg::hex_digit(rx_byte);

	// classify the finished line
	always_comb begin
		push_entry.first  = 32'd0;
		push_entry.second = 32'd0;
		if (qm_q && phase_q != ucp_pkg::PH_PREFIX) begin
			push_entry.status = ucp_pkg::ST_QUERY;
		end else if (phase_q != ucp_pkg::PH_CHECK || das_q != 2'd2) begin
			push_entry.status = ucp_pkg::ST_FORMAT;
		end else if (cde_q || crc_q != rc_q) begin
			push_entry.status = ucp_pkg::ST_CHECK;
		end else if (fe_q) begin
			push_entry.status = ucp_pkg::ST_FORMAT;
		end else begin
			push_entry.status = ucp_pkg::ST_ACCEPT;
			push_entry.first  = acc1_q;
			push_entry.second = acc2_q;
		end
	end

	// next parse state for an accepted byte
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		crc_d   = crc_q;
		qm_d    = qm_q;
		acc1_d  = acc1_q;
		acc2_d  = acc2_q;
		rc_d    = rc_q;
		das_d   = das_q;
		fe_d    = fe_q;
		cde_d   = cde_q;
		te_d    = te_q;
		push    = 1'b0;
		if (accept && rx_byte != ucp_pkg::CH_CR) begin
			if (rx_byte != ucp_pkg::CH_LF && len_q < LEN_MAX) begin
				len_d = len_q + 1'b1;
				if (!te_q) begin
					if (rx_byte == ucp_pkg::CH_NUL) begin
						te_d = 1'b1;
					end else begin
						case (phase_q)
							ucp_pkg::PH_PREFIX: begin
								crc_d = ucp_pkg::crc8_byte(crc_q, rx_byte);
								if (rx_byte != ucp_pkg::query_head(pos)) qm_d = 1'b0;
								if (rx_byte != ucp_pkg::frame_head(pos)) begin
									phase_d = ucp_pkg::PH_REJECT;
								end else if (pos == 2'd3) begin
									phase_d = ucp_pkg::PH_FIRST;
								end
							end
							ucp_pkg::PH_FIRST: begin
								qm_d = 1'b0;
								if (rx_byte == ucp_pkg::CH_STAR) begin
									fe_d    = 1'b1;
									phase_d = ucp_pkg::PH_CHECK;
								end else begin
									crc_d = ucp_pkg::crc8_byte(crc_q, rx_byte);
									if (rx_byte == ucp_pkg::CH_COMMA) begin
										phase_d = ucp_pkg::PH_SECOND;
									end else if (!hx.ok || acc1_q[31:28] != 4'd0) begin
										fe_d = 1'b1;
									end else begin
										acc1_d = {acc1_q[27:0], hx.val};
									end
								end
							end
							ucp_pkg::PH_SECOND: begin
								qm_d = 1'b0;
								if (rx_byte == ucp_pkg::CH_STAR) begin
									phase_d = ucp_pkg::PH_CHECK;
								end else begin
									crc_d = ucp_pkg::crc8_byte(crc_q, rx_byte);
									if (!hx.ok || acc2_q[31:28] != 4'd0) begin
										fe_d = 1'b1;
									end else begin
										acc2_d = {acc2_q[27:0], hx.val};
									end
								end
							end
							ucp_pkg::PH_CHECK: begin
								qm_d = 1'b0;
								if (das_q < 2'd2) begin
									if (!hx.ok) cde_d = 1'b1;
									else rc_d = {rc_q[3:0], hx.val};
								end
								if (das_q != 2'd3) das_d = das_q + 2'd1;
							end
							default: begin
								qm_d = 1'b0;
							end
						endcase
					end
				end
			end else begin
				// newline or overflow: start a fresh line
				push    = (rx_byte == ucp_pkg::CH_LF) && (len_q != '0);
				phase_d = ucp_pkg::PH_PREFIX;
				len_d   = '0;
				crc_d   = 8'd0;
				qm_d    = 1'b1;
				acc1_d  = 32'd0;
				acc2_d  = 32'd0;
				rc_d    = 8'd0;
				das_d   = 2'd0;
				fe_d    = 1'b0;
				cde_d   = 1'b0;
				te_d    = 1'b0;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ucp_pkg::PH_PREFIX;
			len_q   <= '0;
			crc_q   <= 8'd0;
			qm_q    <= 1'b1;
			acc1_q  <= 32'd0;
			acc2_q  <= 32'd0;
			rc_q    <= 8'd0;
			das_q   <= 2'd0;
			fe_q    <= 1'b0;
			cde_q   <= 1'b0;
			te_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			qm_q    <= qm_d;
			acc1_q  <= acc1_d;
			acc2_q  <= acc2_d;
			rc_q    <= rc_d;
			das_q   <= das_d;
			fe_q    <= fe_d;
			cde_q   <= cde_d;
			te_q    <= te_d;
		end
	end

endmodule

// File: rtl/ucp_queue.sv
// short reply queue between the parse front and the reply back end
// depends on ucp_pkg
module ucp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ucp_pkg::reply_t push_entry,
	input  logic            pop,
	output ucp_pkg::reply_t head,
	output ucp_pkg::qstat_t qstat
);

	ucp_pkg::reply_t mem_q [ucp_pkg::QDEPTH];
	logic [ucp_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [ucp_pkg::QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == ucp_pkg::QCNT_W'(ucp_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/ucp_back.sv
// back end: spells out the reply text of the head entry, one character per item
// depends on ucp_pkg
module ucp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ucp_pkg::qstat_t qstat,
	input  ucp_pkg::reply_t head,
	output logic            pop,
	output logic            reply_valid,
	input  logic            reply_stall,
	output logic [7:0]      reply_byte,
	output logic            last_byte,
	output logic [1:0]      status,
	output logic            store_values,
	output logic [31:0]     first_value,
	output logic [31:0]     second_value
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       last;

	assign load        = !qstat.empty && (!valid_q || !reply_stall);
	assign last        = ucp_pkg::reply_last(head.status, idx_q);
	assign pop         = load && last;
	assign reply_valid = valid_q;

	// character index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (!reply_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			reply_byte   <= ucp_pkg::reply_char(head.status, idx_q);
			last_byte    <= last;
			status       <= head.status;
			store_values <= (head.status == ucp_pkg::ST_ACCEPT) && (idx_q == 3'd0);
			first_value  <= head.first;
			second_value <= head.second;
		end
	end

endmodule

// File: rtl/uart_framed_command_parser.sv
// Framed command parser: one received byte per cycle in, reply characters out.
// A newline result enters the reply queue on the cycle after the byte; the reply
// characters (5 to 8) are registered from the head, one per cycle unless stalled.
// Bytes are taken every cycle until the two-entry reply queue is full.
// Reset (arst_n low, asynchronous) clears the line parse, queue and output valid.
module uart_framed_command_parser #(
	parameter int LINE_BYTES = ucp_pkg::LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        reply_valid,
	input  logic        reply_stall,
	output logic [7:0]  reply_byte,
	output logic        last_byte,
	output logic [1:0]  status,
	output logic        store_values,
	output logic [31:0] first_value,
	output logic [31:0] second_value
);

	ucp_pkg::qstat_t qstat;
	ucp_pkg::reply_t push_entry;
	ucp_pkg::reply_t head;
	logic            push;
	logic            pop;

	// line parse and classification
	ucp_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// pending replies
	ucp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// reply text generation
	ucp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.head         (head),
		.pop          (pop),
		.reply_valid  (reply_valid),
		.reply_stall  (reply_stall),
		.reply_byte   (reply_byte),
		.last_byte    (last_byte),
		.status       (status),
		.store_values (store_values),
		.first_value  (first_value),
		.second_value (second_value)
	);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("reply queue pushed while full");

	// a reply keeps flowing until its newline
	a_reply_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !reply_stall && !last_byte |=> reply_valid)
		else $error("gap inside a reply");

	// store flag only on accepted frames
	a_store_status: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && store_values |-> status == ucp_pkg::ST_ACCEPT)
		else $error("store flag on a non-accepted reply");

	// values are zero unless the frame was accepted
	a_values_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && status != ucp_pkg::ST_ACCEPT |-> first_value == 32'd0
			&& second_value == 32'd0)
		else $error("values on a non-accepted reply");

endmodule
